### rtl/aescbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aescbc_pkg
// Shared types, command codes and AES inverse tables for the CBC decrypt unit.
// ----------------------------------------------------------------------------
package aescbc_pkg;

    localparam int ROUND_KEY_WORDS = 44;
    localparam int RK_ROWS         = ROUND_KEY_WORDS / 4;
    localparam int RK_ROW_W        = $clog2(RK_ROWS);
    localparam int LAST_ROUND      = RK_ROWS - 1;

    localparam logic [1:0] CMD_LOAD_KEY   = 2'd0;
    localparam logic [1:0] CMD_LOAD_CHAIN = 2'd1;
    localparam logic [1:0] CMD_DECRYPT    = 2'd2;

    typedef logic [RK_ROW_W-1:0] t_round;

    // controller -> datapath
    typedef struct packed {
        logic   load_key;
        logic   load_chain;
        logic   start;
        logic   do_round;
        logic   last;
        logic   finish;
        t_round round;
    } t_dp_cmd;

    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] s;
        case (x)
            8'h00: s=8'h52; 8'h01: s=8'h09; 8'h02: s=8'h6A; 8'h03: s=8'hD5;
            8'h04: s=8'h30; 8'h05: s=8'h36; 8'h06: s=8'hA5; 8'h07: s=8'h38;
            8'h08: s=8'hBF; 8'h09: s=8'h40; 8'h0A: s=8'hA3; 8'h0B: s=8'h9E;
            8'h0C: s=8'h81; 8'h0D: s=8'hF3; 8'h0E: s=8'hD7; 8'h0F: s=8'hFB;
            8'h10: s=8'h7C; 8'h11: s=8'hE3; 8'h12: s=8'h39; 8'h13: s=8'h82;
            8'h14: s=8'h9B; 8'h15: s=8'h2F; 8'h16: s=8'hFF; 8'h17: s=8'h87;
            8'h18: s=8'h34; 8'h19: s=8'h8E; 8'h1A: s=8'h43; 8'h1B: s=8'h44;
            8'h1C: s=8'hC4; 8'h1D: s=8'hDE; 8'h1E: s=8'hE9; 8'h1F: s=8'hCB;
            8'h20: s=8'h54; 8'h21: s=8'h7B; 8'h22: s=8'h94; 8'h23: s=8'h32;
            8'h24: s=8'hA6; 8'h25: s=8'hC2; 8'h26: s=8'h23; 8'h27: s=8'h3D;
            8'h28: s=8'hEE; 8'h29: s=8'h4C; 8'h2A: s=8'h95; 8'h2B: s=8'h0B;
            8'h2C: s=8'h42; 8'h2D: s=8'hFA; 8'h2E: s=8'hC3; 8'h2F: s=8'h4E;
            8'h30: s=8'h08; 8'h31: s=8'h2E; 8'h32: s=8'hA1; 8'h33: s=8'h66;
            8'h34: s=8'h28; 8'h35: s=8'hD9; 8'h36: s=8'h24; 8'h37: s=8'hB2;
            8'h38: s=8'h76; 8'h39: s=8'h5B; 8'h3A: s=8'hA2; 8'h3B: s=8'h49;
            8'h3C: s=8'h6D; 8'h3D: s=8'h8B; 8'h3E: s=8'hD1; 8'h3F: s=8'h25;
            8'h40: s=8'h72; 8'h41: s=8'hF8; 8'h42: s=8'hF6; 8'h43: s=8'h64;
            8'h44: s=8'h86; 8'h45: s=8'h68; 8'h46: s=8'h98; 8'h47: s=8'h16;
            8'h48: s=8'hD4; 8'h49: s=8'hA4; 8'h4A: s=8'h5C; 8'h4B: s=8'hCC;
            8'h4C: s=8'h5D; 8'h4D: s=8'h65; 8'h4E: s=8'hB6; 8'h4F: s=8'h92;
            8'h50: s=8'h6C; 8'h51: s=8'h70; 8'h52: s=8'h48; 8'h53: s=8'h50;
            8'h54: s=8'hFD; 8'h55: s=8'hED; 8'h56: s=8'hB9; 8'h57: s=8'hDA;
            8'h58: s=8'h5E; 8'h59: s=8'h15; 8'h5A: s=8'h46; 8'h5B: s=8'h57;
            8'h5C: s=8'hA7; 8'h5D: s=8'h8D; 8'h5E: s=8'h9D; 8'h5F: s=8'h84;
            8'h60: s=8'h90; 8'h61: s=8'hD8; 8'h62: s=8'hAB; 8'h63: s=8'h00;
            8'h64: s=8'h8C; 8'h65: s=8'hBC; 8'h66: s=8'hD3; 8'h67: s=8'h0A;
            8'h68: s=8'hF7; 8'h69: s=8'hE4; 8'h6A: s=8'h58; 8'h6B: s=8'h05;
            8'h6C: s=8'hB8; 8'h6D: s=8'hB3; 8'h6E: s=8'h45; 8'h6F: s=8'h06;
            8'h70: s=8'hD0; 8'h71: s=8'h2C; 8'h72: s=8'h1E; 8'h73: s=8'h8F;
            8'h74: s=8'hCA; 8'h75: s=8'h3F; 8'h76: s=8'h0F; 8'h77: s=8'h02;
            8'h78: s=8'hC1; 8'h79: s=8'hAF; 8'h7A: s=8'hBD; 8'h7B: s=8'h03;
            8'h7C: s=8'h01; 8'h7D: s=8'h13; 8'h7E: s=8'h8A; 8'h7F: s=8'h6B;
            8'h80: s=8'h3A; 8'h81: s=8'h91; 8'h82: s=8'h11; 8'h83: s=8'h41;
            8'h84: s=8'h4F; 8'h85: s=8'h67; 8'h86: s=8'hDC; 8'h87: s=8'hEA;
            8'h88: s=8'h97; 8'h89: s=8'hF2; 8'h8A: s=8'hCF; 8'h8B: s=8'hCE;
            8'h8C: s=8'hF0; 8'h8D: s=8'hB4; 8'h8E: s=8'hE6; 8'h8F: s=8'h73;
            8'h90: s=8'h96; 8'h91: s=8'hAC; 8'h92: s=8'h74; 8'h93: s=8'h22;
            8'h94: s=8'hE7; 8'h95: s=8'hAD; 8'h96: s=8'h35; 8'h97: s=8'h85;
            8'h98: s=8'hE2; 8'h99: s=8'hF9; 8'h9A: s=8'h37; 8'h9B: s=8'hE8;
            8'h9C: s=8'h1C; 8'h9D: s=8'h75; 8'h9E: s=8'hDF; 8'h9F: s=8'h6E;
            8'hA0: s=8'h47; 8'hA1: s=8'hF1; 8'hA2: s=8'h1A; 8'hA3: s=8'h71;
            8'hA4: s=8'h1D; 8'hA5: s=8'h29; 8'hA6: s=8'hC5; 8'hA7: s=8'h89;
            8'hA8: s=8'h6F; 8'hA9: s=8'hB7; 8'hAA: s=8'h62; 8'hAB: s=8'h0E;
            8'hAC: s=8'hAA; 8'hAD: s=8'h18; 8'hAE: s=8'hBE; 8'hAF: s=8'h1B;
            8'hB0: s=8'hFC; 8'hB1: s=8'h56; 8'hB2: s=8'h3E; 8'hB3: s=8'h4B;
            8'hB4: s=8'hC6; 8'hB5: s=8'hD2; 8'hB6: s=8'h79; 8'hB7: s=8'h20;
            8'hB8: s=8'h9A; 8'hB9: s=8'hDB; 8'hBA: s=8'hC0; 8'hBB: s=8'hFE;
            8'hBC: s=8'h78; 8'hBD: s=8'hCD; 8'hBE: s=8'h5A; 8'hBF: s=8'hF4;
            8'hC0: s=8'h1F; 8'hC1: s=8'hDD; 8'hC2: s=8'hA8; 8'hC3: s=8'h33;
            8'hC4: s=8'h88; 8'hC5: s=8'h07; 8'hC6: s=8'hC7; 8'hC7: s=8'h31;
            8'hC8: s=8'hB1; 8'hC9: s=8'h12; 8'hCA: s=8'h10; 8'hCB: s=8'h59;
            8'hCC: s=8'h27; 8'hCD: s=8'h80; 8'hCE: s=8'hEC; 8'hCF: s=8'h5F;
            8'hD0: s=8'h60; 8'hD1: s=8'h51; 8'hD2: s=8'h7F; 8'hD3: s=8'hA9;
            8'hD4: s=8'h19; 8'hD5: s=8'hB5; 8'hD6: s=8'h4A; 8'hD7: s=8'h0D;
            8'hD8: s=8'h2D; 8'hD9: s=8'hE5; 8'hDA: s=8'h7A; 8'hDB: s=8'h9F;
            8'hDC: s=8'h93; 8'hDD: s=8'hC9; 8'hDE: s=8'h9C; 8'hDF: s=8'hEF;
            8'hE0: s=8'hA0; 8'hE1: s=8'hE0; 8'hE2: s=8'h3B; 8'hE3: s=8'h4D;
            8'hE4: s=8'hAE; 8'hE5: s=8'h2A; 8'hE6: s=8'hF5; 8'hE7: s=8'hB0;
            8'hE8: s=8'hC8; 8'hE9: s=8'hEB; 8'hEA: s=8'hBB; 8'hEB: s=8'h3C;
            8'hEC: s=8'h83; 8'hED: s=8'h53; 8'hEE: s=8'h99; 8'hEF: s=8'h61;
            8'hF0: s=8'h17; 8'hF1: s=8'h2B; 8'hF2: s=8'h04; 8'hF3: s=8'h7E;
            8'hF4: s=8'hBA; 8'hF5: s=8'h77; 8'hF6: s=8'hD6; 8'hF7: s=8'h26;
            8'hF8: s=8'hE1; 8'hF9: s=8'h69; 8'hFA: s=8'h14; 8'hFB: s=8'h63;
            8'hFC: s=8'h55; 8'hFD: s=8'h21; 8'hFE: s=8'h0C; 8'hFF: s=8'h7D;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] gf_dbl(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
    endfunction

    // InvMixColumns column {0E,09,0D,0B} * InvSbox[x]
    function automatic logic [31:0] inv_col(input logic [7:0] x);
        logic [7:0] x1, x2, x4, x8;
        x1 = inv_sbox(x);
        x2 = gf_dbl(x1);
        x4 = gf_dbl(x2);
        x8 = gf_dbl(x4);
        return {x8 ^ x4 ^ x2, x8 ^ x1, x8 ^ x4 ^ x1, x8 ^ x2 ^ x1};
    endfunction

endpackage

### rtl/aescbc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aescbc_ctrl
// Command decode and round sequencer for the CBC decrypt unit.
// ----------------------------------------------------------------------------
module aescbc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [1:0]           i_command,
    output logic                 o_stall,
    input  logic                 i_out_busy,
    output aescbc_pkg::t_dp_cmd  o_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ROUND = 2'd1;
    localparam logic [1:0] ST_WAIT  = 2'd2;

    logic [1:0]          r_state, n_state;
    aescbc_pkg::t_round  r_round, n_round;
    logic                accept;

    assign o_stall = (r_state != ST_IDLE);
    assign accept  = i_valid && (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        o_cmd   = '0;
        o_cmd.round = r_round;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.load_key   = (i_command == aescbc_pkg::CMD_LOAD_KEY);
                    o_cmd.load_chain = (i_command == aescbc_pkg::CMD_LOAD_CHAIN);
                    if (i_command == aescbc_pkg::CMD_DECRYPT) begin
                        o_cmd.start = 1'b1;
                        n_round     = aescbc_pkg::t_round'(1);
                        n_state     = ST_ROUND;
                    end
                end
            end
            ST_ROUND: begin
                o_cmd.do_round = 1'b1;
                o_cmd.last = (r_round == aescbc_pkg::t_round'(aescbc_pkg::LAST_ROUND));
                if (o_cmd.last) begin
                    n_state = ST_WAIT;
                end else begin
                    n_round = r_round + 1'b1;
                end
            end
            ST_WAIT: begin
                // result register must be free before we publish
                if (!i_out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
        end
    end

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> (r_round != '0))
        else $error("round counter zero while running");
    a_last_to_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND && o_cmd.last) |=> (r_state == ST_WAIT))
        else $error("last round did not enter wait");
    a_start_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == ST_ROUND))
        else $error("decrypt start did not enter rounds");

endmodule

### rtl/aescbc_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aescbc_dpath
// Round-key store, chain register, round state and result register.
// ----------------------------------------------------------------------------
module aescbc_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  aescbc_pkg::t_dp_cmd  i_cmd,
    input  logic [5:0]           i_word_index,
    input  logic [31:0]          i_key_word,
    input  logic [63:0]          i_cipher_high,
    input  logic [63:0]          i_cipher_low,
    input  logic                 i_final_block,
    input  logic                 i_out_stall,
    output logic                 o_out_busy,
    output logic                 o_valid,
    output logic [63:0]          o_plain_high,
    output logic [63:0]          o_plain_low,
    output logic                 o_final_out
);

    // round keys stored as 11 rows of 128 bits, row read registered
    logic [127:0]  r_rk_mem [aescbc_pkg::RK_ROWS];
    logic [127:0]  r_rk_row;
    logic [127:0]  r_state;
    logic [127:0]  r_cin;
    logic [127:0]  r_chain;
    logic          r_final;
    logic          r_valid;
    logic [127:0]  r_plain;
    logic [127:0]  round_out;
    logic [127:0]  last_out;
    logic [31:0]   st [4];
    logic [31:0]   rk [4];
    logic [31:0]   mc0 [4];
    logic [31:0]   mc1 [4];
    logic [31:0]   mc2 [4];
    logic [31:0]   mc3 [4];
    logic [31:0]   tw [4];
    logic [31:0]   lw [4];
    aescbc_pkg::t_round rd_row;
    logic          key_ok;

    assign key_ok = (i_word_index < 6'(aescbc_pkg::ROUND_KEY_WORDS));

    // write one 32-bit word lane of a row
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_key && key_ok) begin
            case (i_word_index[1:0])
                2'd0: r_rk_mem[i_word_index[5:2]][127:96] <= i_key_word;
                2'd1: r_rk_mem[i_word_index[5:2]][95:64]  <= i_key_word;
                2'd2: r_rk_mem[i_word_index[5:2]][63:32]  <= i_key_word;
                default: r_rk_mem[i_word_index[5:2]][31:0] <= i_key_word;
            endcase
        end
        r_rk_row <= r_rk_mem[rd_row];
    end

    // row 0 is fetched at acceptance, later rows follow the round counter
    always_comb rd_row = i_cmd.start ? '0 : i_cmd.round;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            st[c] = r_state[127-32*c -: 32];
            rk[c] = r_rk_row[127-32*c -: 32];
        end
        for (int c = 0; c < 4; c++) begin
            mc0[c] = aescbc_pkg::inv_col(st[c][31:24]);
            mc1[c] = aescbc_pkg::inv_col(st[(c+3)%4][23:16]);
            mc2[c] = aescbc_pkg::inv_col(st[(c+2)%4][15:8]);
            mc3[c] = aescbc_pkg::inv_col(st[(c+1)%4][7:0]);
            tw[c]  = mc0[c]
                   ^ {mc1[c][7:0], mc1[c][31:8]}
                   ^ {mc2[c][15:0], mc2[c][31:16]}
                   ^ {mc3[c][23:0], mc3[c][31:24]};
            lw[c] = {aescbc_pkg::inv_sbox(st[c][31:24]),
                     aescbc_pkg::inv_sbox(st[(c+3)%4][23:16]),
                     aescbc_pkg::inv_sbox(st[(c+2)%4][15:8]),
                     aescbc_pkg::inv_sbox(st[(c+1)%4][7:0])};
            round_out[127-32*c -: 32] = tw[c] ^ rk[c];
            last_out[127-32*c -: 32]  = lw[c] ^ rk[c];
        end
    end

    // state: key row 0 read, then add, then 9 table rounds, last round
    logic r_first;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b0;
        end else begin
            r_first <= i_cmd.start;
        end
        if (i_cmd.start) begin
            r_cin   <= {i_cipher_high, i_cipher_low};
            r_final <= i_final_block;
        end
        if (i_cmd.do_round) begin
            if (r_first) begin
                r_state <= r_cin ^ r_rk_row;
            end else begin
                r_state <= round_out;
            end
        end
    end

    // last-round output computed in wait state from the final row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cmd.load_chain && i_word_index < 6'd4) begin
                case (i_word_index[1:0])
                    2'd0: r_chain[127:96] <= i_key_word;
                    2'd1: r_chain[95:64]  <= i_key_word;
                    2'd2: r_chain[63:32]  <= i_key_word;
                    default: r_chain[31:0] <= i_key_word;
                endcase
            end
            if (i_cmd.finish) begin
                r_chain <= r_cin;
                r_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
        if (i_cmd.finish) begin
            r_plain     <= last_out ^ r_chain;
            o_final_out <= r_final;
        end
    end

    assign o_out_busy   = r_valid && i_out_stall;
    assign o_valid      = r_valid;
    assign o_plain_high = r_plain[127:64];
    assign o_plain_low  = r_plain[63:0];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_out_stall) |=> $stable(r_plain))
        else $error("result changed while stalled");
    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> !(r_valid && i_out_stall))
        else $error("result overwritten");
    a_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_chain == $past(r_cin)))
        else $error("chain not updated");

endmodule

### rtl/aes128_cbc_decrypt_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_cbc_decrypt_unit
// AES-128 CBC decryption (equivalent inverse cipher), round keys loaded.
// ----------------------------------------------------------------------------
// Load commands complete on acceptance. A decrypt command writes its result
// after the initial key add, nine table rounds and the final round, one
// round per cycle through the single round unit reading one 128-bit
// round-key row per cycle, row 0 fetched at acceptance; the final round
// waits while the result register is still held by a stalled consumer. The
// input stays stalled until that result is written, so no new decrypt is
// accepted before the last is written. One block is in flight at a time; a finished
// block may wait in the output register while the next command is accepted.
module aes128_cbc_decrypt_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_stall,
    input  logic [1:0]   i_command,
    input  logic [5:0]   i_word_index,
    input  logic [31:0]  i_key_word,
    input  logic [63:0]  i_cipher_high,
    input  logic [63:0]  i_cipher_low,
    input  logic         i_final_block,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [63:0]  o_plain_high,
    output logic [63:0]  o_plain_low,
    output logic         o_final_out
);

    aescbc_pkg::t_dp_cmd cmd;
    logic                out_busy;

    aescbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_command  (i_command),
        .o_stall    (o_stall),
        .i_out_busy (out_busy),
        .o_cmd      (cmd)
    );

    aescbc_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_word_index  (i_word_index),
        .i_key_word    (i_key_word),
        .i_cipher_high (i_cipher_high),
        .i_cipher_low  (i_cipher_low),
        .i_final_block (i_final_block),
        .i_out_stall   (i_stall),
        .o_out_busy    (out_busy),
        .o_valid       (o_valid),
        .o_plain_high  (o_plain_high),
        .o_plain_low   (o_plain_low),
        .o_final_out   (o_final_out)
    );

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives AES-128 CBC decryption transactions into aes128_cbc_decrypt_unit:
// round-key and chain-word loads, then decrypts with random ciphertext.
// A scoreboard predicts each plaintext block and checks the output stream.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [63:0] plain_high;
        logic [63:0] plain_low;
        logic        final_out;
    } t_plain;

    class cbc_scoreboard;
        logic [31:0] rk [aescbc_pkg::ROUND_KEY_WORDS];
        logic [31:0] chain [4];
        t_plain      pending [$];
        int          errors;

        function new();
            foreach (rk[i]) rk[i] = '0;
            foreach (chain[i]) chain[i] = '0;
            errors = 0;
        endfunction

        function logic [31:0] ror(logic [31:0] v, int n);
            return (v >> n) | (v << (32 - n));
        endfunction

        function logic [7:0] bsel(logic [31:0] w, int lane);
            return w[31 - 8*lane -: 8];
        endfunction

        // column of {0E,09,0D,0B} * InvSbox, computed locally
        function logic [31:0] mixcol(logic [7:0] x);
            logic [7:0] a1, a2, a4, a8;
            a1 = aescbc_pkg::inv_sbox(x);
            a2 = {a1[6:0], 1'b0} ^ (a1[7] ? 8'h1B : 8'h00);
            a4 = {a2[6:0], 1'b0} ^ (a2[7] ? 8'h1B : 8'h00);
            a8 = {a4[6:0], 1'b0} ^ (a4[7] ? 8'h1B : 8'h00);
            return {a8 ^ a4 ^ a2, a8 ^ a1, a8 ^ a4 ^ a1, a8 ^ a2 ^ a1};
        endfunction

        function void note_input(logic [1:0] cmd, logic [5:0] idx, logic [31:0] kw,
                                 logic [63:0] ch, logic [63:0] cl, logic fin);
            logic [31:0] cin [4];
            logic [31:0] st [4];
            logic [31:0] nx [4];
            logic [31:0] res [4];
            int k;
            t_plain p;
            if (cmd == aescbc_pkg::CMD_LOAD_KEY) begin
                if (idx < aescbc_pkg::ROUND_KEY_WORDS) rk[idx] = kw;
            end else if (cmd == aescbc_pkg::CMD_LOAD_CHAIN) begin
                if (idx < 4) chain[idx] = kw;
            end else if (cmd == aescbc_pkg::CMD_DECRYPT) begin
                cin[0] = ch[63:32]; cin[1] = ch[31:0];
                cin[2] = cl[63:32]; cin[3] = cl[31:0];
                for (int c = 0; c < 4; c++) st[c] = cin[c] ^ rk[c];
                k = 4;
                for (int r = 0; r < 9; r++) begin
                    for (int c = 0; c < 4; c++)
                        nx[c] = mixcol(bsel(st[c], 0))
                              ^ ror(mixcol(bsel(st[(c+3)%4], 1)), 8)
                              ^ ror(mixcol(bsel(st[(c+2)%4], 2)), 16)
                              ^ ror(mixcol(bsel(st[(c+1)%4], 3)), 24)
                              ^ rk[k+c];
                    st = nx;
                    k += 4;
                end
                for (int c = 0; c < 4; c++) begin
                    res[c] = {aescbc_pkg::inv_sbox(bsel(st[c], 0)),
                              aescbc_pkg::inv_sbox(bsel(st[(c+3)%4], 1)),
                              aescbc_pkg::inv_sbox(bsel(st[(c+2)%4], 2)),
                              aescbc_pkg::inv_sbox(bsel(st[(c+1)%4], 3))}
                           ^ rk[k+c] ^ chain[c];
                    chain[c] = cin[c];
                end
                p.plain_high = {res[0], res[1]};
                p.plain_low  = {res[2], res[3]};
                p.final_out  = fin;
                pending.push_back(p);
            end
        endfunction

        function void check_result(logic [63:0] ph, logic [63:0] pl, logic fo);
            t_plain e;
            if (pending.size() == 0) begin
                $error("unexpected plaintext transaction %h %h", ph, pl);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (ph !== e.plain_high) begin
                $error("plain_high exp %h got %h", e.plain_high, ph); errors++;
            end
            if (pl !== e.plain_low) begin
                $error("plain_low exp %h got %h", e.plain_low, pl); errors++;
            end
            if (fo !== e.final_out) begin
                $error("final_out exp %b got %b", e.final_out, fo); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_command = '0;
    logic [5:0]  i_word_index = '0;
    logic [31:0] i_key_word = '0;
    logic [63:0] i_cipher_high = '0;
    logic [63:0] i_cipher_low = '0;
    logic        i_final_block = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b1;
    logic [63:0] o_plain_high;
    logic [63:0] o_plain_low;
    logic        o_final_out;

    cbc_scoreboard sb;
    bit hold_off = 0;

    aes128_cbc_decrypt_unit dut (.*);

    always #4 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("testbench: FAIL");
        $finish;
    end

    // one transaction; valid stays high if the next send follows without a gap
    task automatic send(logic [1:0] cmd, logic [5:0] idx, logic [31:0] kw,
                        logic [63:0] ch, logic [63:0] cl, logic fin);
        i_valid       <= 1'b1;
        i_command     <= cmd;
        i_word_index  <= idx;
        i_key_word    <= kw;
        i_cipher_high <= ch;
        i_cipher_low  <= cl;
        i_final_block <= fin;
        do @(posedge i_clk); while (o_stall);
        sb.note_input(cmd, idx, kw, ch, cl, fin);
    endtask

    task automatic gap();
        int n;
        n = $urandom_range(0, 3) == 0 ? $urandom_range(1, 30) : 0;
        if (n > 0) begin
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    task automatic load_keys();
        for (int i = 0; i < aescbc_pkg::ROUND_KEY_WORDS; i++) begin
            send(aescbc_pkg::CMD_LOAD_KEY, i[5:0], $urandom, rnd64(), rnd64(),
                 1'($urandom_range(0, 1)));
            gap();
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_plain_high, o_plain_low, o_final_out);
    end

    // receiver: random stall pattern, with quiet and busy stretches
    initial begin
        int mode;
        forever begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(10, 200)) begin
                @(posedge i_clk);
                if (hold_off) i_stall <= 1'b1;
                else if (mode == 0) i_stall <= 1'b0;
                else if (mode == 1) i_stall <= ($urandom_range(0, 3) == 0);
                else i_stall <= ($urandom_range(0, 3) != 0);
            end
        end
    end

    initial begin
        int r;
        int waited;
        int items;
        logic [1:0] c;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: keys, extreme chain words, out-of-range indexes, unused command, decrypts
        load_keys();
        send(aescbc_pkg::CMD_LOAD_CHAIN, 6'd0, 32'hFFFF_FFFF, '1, '1, 1'b1);
        send(aescbc_pkg::CMD_LOAD_CHAIN, 6'd3, 32'h0, '0, '0, 1'b0);
        send(aescbc_pkg::CMD_LOAD_CHAIN, 6'd4, 32'hDEAD_BEEF, '0, '0, 1'b0);
        send(aescbc_pkg::CMD_LOAD_CHAIN, 6'd63, 32'hFFFF_FFFF, '0, '0, 1'b0);
        send(aescbc_pkg::CMD_LOAD_KEY, 6'd44, 32'hFFFF_FFFF, '0, '0, 1'b0);
        send(aescbc_pkg::CMD_LOAD_KEY, 6'd63, 32'hA5A5_5A5A, '1, '1, 1'b1);
        send(CMD_UNUSED, 6'd0, 32'h1234_5678, '1, '1, 1'b1);
        send(aescbc_pkg::CMD_DECRYPT, 6'd0, 32'h0, '0, '0, 1'b0);
        send(aescbc_pkg::CMD_DECRYPT, 6'd63, 32'hFFFF_FFFF, '1, '1, 1'b1);
        send(aescbc_pkg::CMD_DECRYPT, 6'd5, 32'h0, 64'h8000_0000_0000_0001,
             64'h0123_4567_89AB_CDEF, 1'b0);
        send(aescbc_pkg::CMD_LOAD_KEY, 6'd43, 32'hFFFF_FFFF, '0, '0, 1'b0);
        send(aescbc_pkg::CMD_LOAD_KEY, 6'd0, 32'h0, '0, '0, 1'b0);
        send(aescbc_pkg::CMD_DECRYPT, 6'd0, 32'h0, rnd64(), rnd64(), 1'b1);

        // long receiver hold-off while the sender keeps offering decrypts
        hold_off = 1;
        fork
            begin
                waited = 0;
                while (waited < 200) begin
                    @(posedge i_clk);
                    waited++;
                end
                hold_off = 0;
            end
            for (int i = 0; i < 8; i++)
                send(aescbc_pkg::CMD_DECRYPT, 6'd0, 32'h0, rnd64(), rnd64(),
                     1'($urandom_range(0, 1)));
        join

        // random: mostly decrypt runs, chain reloads, some key reloads and noise
        items = 0;
        while (items < 1400) begin
            r = $urandom_range(0, 99);
            if (r < 2) begin
                load_keys();
                items += aescbc_pkg::ROUND_KEY_WORDS;
            end else begin
                if (r < 70) c = aescbc_pkg::CMD_DECRYPT;
                else if (r < 85) c = aescbc_pkg::CMD_LOAD_CHAIN;
                else if (r < 95) c = aescbc_pkg::CMD_LOAD_KEY;
                else c = CMD_UNUSED;
                send(c, (c == aescbc_pkg::CMD_LOAD_CHAIN && $urandom_range(0, 4) != 0)
                        ? 6'($urandom_range(0, 3)) : 6'($urandom_range(0, 63)),
                     $urandom, rnd64(), rnd64(), 1'($urandom_range(0, 1)));
                items++;
            end
            gap();
        end
        i_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (sb.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
